[hw/rtl/esc_u8_pkg.sv]
`default_nettype none

package esc_u8_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned TAIL_LEN = 6;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] tlen_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_UTF8,
    MODE_ESC,
    MODE_HEX_X,
    MODE_HEX_U
  } mode_e;

  // One self-contained run of bytes for the decoder, first byte in bytes[0].
  typedef struct packed {
    byte_t [TAIL_LEN-1:0] bytes;
    tlen_t                len;
    logic                 last;
  } job_t;

  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LX     = 8'h78;
  localparam byte_t CH_UX     = 8'h58;
  localparam byte_t CH_LU     = 8'h75;
  localparam byte_t CH_LN     = 8'h6E;
  localparam byte_t CH_LR     = 8'h72;
  localparam byte_t CH_LT     = 8'h74;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_LA     = 8'h61;
  localparam byte_t CH_LF     = 8'h66;
  localparam byte_t CH_UA     = 8'h41;
  localparam byte_t CH_UF     = 8'h46;
  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_NUL    = 8'h00;

  function automatic logic [1:0] followers_of(input byte_t c);
    logic [1:0] f;
    f = 2'd0;
    if ((c & 8'hE0) == 8'hC0) begin
      f = 2'd1;
    end else if ((c & 8'hF0) == 8'hE0) begin
      f = 2'd2;
    end else if ((c & 8'hF8) == 8'hF0) begin
      f = 2'd3;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/esc_u8_if.sv]
`default_nettype none

interface esc_u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last;

  modport source (output valid, output byte_req, output last, input ready);
  modport sink (input valid, input byte_req, input last, output ready);
endinterface

interface esc_u8_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        bad_hex;
  logic        end_of_run;

  modport source (output valid, output code_point, output bad_hex, output end_of_run,
                  input ready);
  modport sink (input valid, input code_point, input bad_hex, input end_of_run,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/esc_u8_front.sv]
`default_nettype none

module esc_u8_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  esc_u8_in_if.sink        in_i,
  output esc_u8_pkg::job_t job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);
  import esc_u8_pkg::*;

  mode_e       mode_q, mode_d;
  logic [2:0]  pcnt_q, pcnt_d;
  logic [2:0]  ncnt_q, ncnt_d;
  byte_t       pend_q [4];
  logic        pend_we;
  logic [1:0]  pend_widx;
  logic [1:0]  cnt;
  logic [1:0]  pre_len;
  logic [1:0]  pend_len;
  byte_t       pre0;
  byte_t       pre1;
  logic        accept;
  logic        push;
  logic [1:0]  fol;
  logic [2:0]  k;
  byte_t       b;

  assign b      = in_i.byte_req;
  assign accept = in_i.valid && job_ready_i;
  assign in_i.ready = job_ready_i;
  assign cnt    = pcnt_q[1:0];
  assign fol    = followers_of(b);

  always_comb begin
    pre_len  = 2'd0;
    pend_len = 2'd0;
    pre0     = CH_BSLASH;
    pre1     = CH_LX;
    case (mode_q)
      MODE_UTF8: begin
        pend_len = cnt;
      end
      MODE_ESC: begin
        pre_len = 2'd1;
      end
      MODE_HEX_X: begin
        pre_len  = 2'd2;
        pend_len = cnt;
      end
      MODE_HEX_U: begin
        pre_len  = 2'd2;
        pre1     = CH_LU;
        pend_len = cnt;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    k = 3'd0;
    for (int j = 0; j < TAIL_LEN; j++) begin
      job_o.bytes[j] = CH_NUL;
      if (3'(j) < {1'b0, pre_len}) begin
        job_o.bytes[j] = (j == 0) ? pre0 : pre1;
      end else begin
        k = 3'(j) - {1'b0, pre_len};
        if (k < {1'b0, pend_len}) begin
          job_o.bytes[j] = pend_q[k[1:0]];
        end else if (k == {1'b0, pend_len}) begin
          job_o.bytes[j] = b;
        end
      end
    end
    job_o.len  = {1'b0, pre_len} + {1'b0, pend_len} + 3'd1;
    job_o.last = in_i.last;
  end

  always_comb begin
    mode_d    = mode_q;
    pcnt_d    = pcnt_q;
    ncnt_d    = ncnt_q;
    pend_we   = 1'b0;
    pend_widx = cnt;
    push      = 1'b0;
    if (accept) begin
      if (in_i.last) begin
        push   = 1'b1;
        mode_d = MODE_IDLE;
        pcnt_d = 3'd0;
        ncnt_d = 3'd0;
      end else begin
        case (mode_q)
          MODE_UTF8, MODE_HEX_X, MODE_HEX_U: begin
            pend_we = 1'b1;
            pcnt_d  = {1'b0, cnt} + 3'd1;
            ncnt_d  = ncnt_q - 3'd1;
            if (ncnt_q == 3'd1) begin
              push   = 1'b1;
              mode_d = MODE_IDLE;
              pcnt_d = 3'd0;
              ncnt_d = 3'd0;
            end
          end
          MODE_ESC: begin
            if (b == CH_LX || b == CH_LU) begin
              mode_d = (b == CH_LX) ? MODE_HEX_X : MODE_HEX_U;
              pcnt_d = 3'd0;
              ncnt_d = (b == CH_LX) ? 3'd2 : 3'd4;
            end else begin
              push   = 1'b1;
              mode_d = MODE_IDLE;
              pcnt_d = 3'd0;
              ncnt_d = 3'd0;
            end
          end
          default: begin
            if (b == CH_BSLASH) begin
              mode_d = MODE_ESC;
            end else if (fol == 2'd0) begin
              push   = 1'b1;
              mode_d = MODE_IDLE;
              pcnt_d = 3'd0;
              ncnt_d = 3'd0;
            end else begin
              mode_d    = MODE_UTF8;
              pend_we   = 1'b1;
              pend_widx = 2'd0;
              pcnt_d    = 3'd1;
              ncnt_d    = {1'b0, fol};
            end
          end
        endcase
      end
    end
  end

  assign job_valid_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pcnt_q <= 3'd0;
      ncnt_q <= 3'd0;
    end else begin
      mode_q <= mode_d;
      pcnt_q <= pcnt_d;
      ncnt_q <= ncnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q[pend_widx] <= b;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/esc_u8_fifo.sv]
`default_nettype none

module esc_u8_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  esc_u8_pkg::job_t data_i,
  output logic             full_o,
  output logic             valid_o,
  output esc_u8_pkg::job_t data_o,
  input  logic             pop_i
);
  import esc_u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/esc_u8_back.sv]
`default_nettype none

module esc_u8_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  esc_u8_pkg::job_t job_i,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  esc_u8_out_if.source     out_o
);
  import esc_u8_pkg::*;

  function automatic logic is_hex(input byte_t c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input byte_t c);
    logic [3:0] v;
    v = c[3:0];
    if (c > CH_9) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Returns {bad, value}; the value is the run of leading hex digits.
  function automatic logic [16:0] parse_hex(input byte_t [3:0] p, input logic four);
    logic [1:0]  start;
    logic [2:0]  n;
    logic        run;
    logic [15:0] v;
    start = 2'd0;
    n     = four ? 3'd4 : 3'd2;
    run   = 1'b1;
    v     = 16'h0;
    if (four && p[0] == CH_0 && (p[1] == CH_LX || p[1] == CH_UX) && is_hex(p[2])) begin
      start = 2'd2;
    end
    for (int j = 0; j < 4; j++) begin
      if (3'(j) >= {1'b0, start} && 3'(j) < n && run) begin
        if (is_hex(p[j])) begin
          v = {v[11:0], hex_val(p[j])};
        end else begin
          run = 1'b0;
        end
      end
    end
    return is_hex(p[start]) ? {1'b0, v} : {1'b1, 16'h0};
  endfunction

  function automatic byte_t simple_escape(input byte_t c);
    byte_t r;
    case (c)
      CH_LN:   r = CH_NL;
      CH_LR:   r = CH_CR;
      CH_LT:   r = CH_TAB;
      CH_0:    r = CH_NUL;
      default: r = c;
    endcase
    return r;
  endfunction

  logic                 wv_q, wv_d;
  byte_t [TAIL_LEN-1:0] wb_q, wb_d;
  tlen_t                wrem_q, wrem_d;
  logic                 wlast_q, wlast_d;
  logic                 ov_q, ov_d;
  logic [CP_W-1:0]      ocp_q, ocp_d;
  logic                 obad_q, obad_d;
  logic                 oeor_q, oeor_d;

  logic [CP_W-1:0]      tok_cp;
  logic                 tok_bad;
  tlen_t                tok_len;
  logic [16:0]          hex_res;
  logic                 is_u;
  logic [1:0]           fol;
  byte_t [TAIL_LEN-1:0] wb_shift;
  logic [3:0]           sidx;
  logic                 fire;
  logic                 done;
  logic                 load;

  assign is_u    = (wb_q[1] == CH_LU);
  assign hex_res = parse_hex(wb_q[5:2], is_u);
  assign fol     = followers_of(wb_q[0]);

  always_comb begin
    tok_cp  = {13'h0, wb_q[0]};
    tok_bad = 1'b0;
    tok_len = 3'd1;
    if (wb_q[0] == CH_BSLASH && wrem_q >= 3'd2) begin
      tok_len = 3'd2;
      if (wb_q[1] == CH_LX || wb_q[1] == CH_LU) begin
        tok_cp = '0;
        if ((!is_u && wrem_q >= 3'd4) || (is_u && wrem_q >= 3'd6)) begin
          tok_cp  = {5'h0, hex_res[15:0]};
          tok_bad = hex_res[16];
          tok_len = is_u ? 3'd6 : 3'd4;
        end
      end else begin
        tok_cp = {13'h0, simple_escape(wb_q[1])};
      end
    end else if (fol != 2'd0 && {1'b0, fol} < wrem_q) begin
      tok_len = {1'b0, fol} + 3'd1;
      case (fol)
        2'd1:    tok_cp = {10'h0, wb_q[0][4:0], wb_q[1][5:0]};
        2'd2:    tok_cp = {5'h0, wb_q[0][3:0], wb_q[1][5:0], wb_q[2][5:0]};
        default: tok_cp = {wb_q[0][2:0], wb_q[1][5:0], wb_q[2][5:0], wb_q[3][5:0]};
      endcase
    end
  end

  always_comb begin
    sidx = 4'd0;
    for (int j = 0; j < TAIL_LEN; j++) begin
      sidx        = 4'(j) + {1'b0, tok_len};
      wb_shift[j] = (sidx < 4'(TAIL_LEN)) ? wb_q[sidx[2:0]] : CH_NUL;
    end
  end

  assign fire      = wv_q && (!ov_q || out_o.ready);
  assign done      = (tok_len == wrem_q);
  assign load      = job_valid_i && (!wv_q || (fire && done));
  assign job_pop_o = load;

  always_comb begin
    wv_d    = wv_q;
    wb_d    = wb_q;
    wrem_d  = wrem_q;
    wlast_d = wlast_q;
    ov_d    = ov_q;
    ocp_d   = ocp_q;
    obad_d  = obad_q;
    oeor_d  = oeor_q;
    if (load) begin
      wv_d    = 1'b1;
      wb_d    = job_i.bytes;
      wrem_d  = job_i.len;
      wlast_d = job_i.last;
    end else if (fire) begin
      wv_d   = !done;
      wb_d   = wb_shift;
      wrem_d = wrem_q - tok_len;
    end
    if (fire) begin
      ov_d   = 1'b1;
      ocp_d  = tok_cp;
      obad_d = tok_bad;
      oeor_d = wlast_q && done;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      wv_q <= wv_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_q    <= wb_d;
    wrem_q  <= wrem_d;
    wlast_q <= wlast_d;
    ocp_q   <= ocp_d;
    obad_q  <= obad_d;
    oeor_q  <= oeor_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.code_point = ocp_q;
  assign out_o.bad_hex    = obad_q;
  assign out_o.end_of_run = oeor_q;

endmodule

`default_nettype wire

[hw/rtl/escaped_utf8_to_code_points_unit.sv]
// Throughput: one byte per cycle while the queue has room, limited by the single-token decoder
// in the back end, which stalls on output back-pressure. A final byte whose flushed tail splits
// into several code points holds the decoder until each is sent, up to four code points.
// Reset is asynchronous and active low; it clears the mode, counters, queue and valid flags,
// while the buffered sequence bytes are not reset.
`default_nettype none

module escaped_utf8_to_code_points_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  esc_u8_in_if.sink    in_i,
  esc_u8_out_if.source out_o
);
  import esc_u8_pkg::*;

  job_t push_job;
  logic push_valid;
  logic q_full;
  job_t pop_job;
  logic pop_valid;
  logic pop;

  esc_u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (!q_full)
  );

  esc_u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (push_job),
    .full_o  (q_full),
    .valid_o (pop_valid),
    .data_o  (pop_job),
    .pop_i   (pop)
  );

  esc_u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[hw/rtl/esc_u8_checker.sv]
`default_nettype none

module esc_u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [20:0] out_code_point_i,
  input logic        out_bad_hex_i,
  input logic        out_end_of_run_i
);

  logic [2:0] owed_q, owed_d;
  logic       last_in;
  logic       eor_out;

  assign last_in = in_valid_i && in_ready_i && in_last_i;
  assign eor_out = out_valid_i && out_ready_i && out_end_of_run_i;

  // Strings whose final byte was taken but whose closing code point is not yet delivered.
  always_comb begin
    owed_d = owed_q;
    if (last_in && !eor_out) begin
      owed_d = owed_q + 3'd1;
    end else if (!last_in && eor_out) begin
      owed_d = owed_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= 3'd0;
    end else begin
      owed_q <= owed_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_code_point_i, out_bad_hex_i, out_end_of_run_i}))
    else $error("Output transaction changed while stalled.");

  a_bad_hex_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_hex_i |-> out_code_point_i == 21'h0)
    else $error("A bad hex escape carried a nonzero code point.");

  a_end_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eor_out |-> owed_q != 3'd0)
    else $error("End of run delivered without an accepted final byte.");

endmodule

bind escaped_utf8_to_code_points_unit esc_u8_checker u_esc_u8_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.last),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_code_point_i (out_o.code_point),
  .out_bad_hex_i    (out_o.bad_hex),
  .out_end_of_run_i (out_o.end_of_run)
);

`default_nettype wire

[sim/escaped_utf8_to_code_points_unit_test.sv]
`timescale 1ns / 100ps

module escaped_utf8_to_code_points_unit_test;
  import esc_u8_pkg::*;

  localparam realtime     HALF_PERIOD = 4ns;
  localparam int unsigned MAX_CPS     = 4;
  localparam int unsigned RAND_ITEMS  = 80;
  localparam int unsigned CALM_ITEMS  = 20;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned HOLD_AT     = 8;
  localparam int unsigned DRAIN_AT    = 45;
  localparam int unsigned STUCK_LIMIT = 1000;
  localparam int unsigned N_DIRECTED  = 27;
  localparam byte_t       CH_DQUOTE   = 8'h22;

  typedef byte_t seq_t [8];

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            bad;
    logic            eor;
  } cp_res_t;

  typedef struct packed {
    byte_t           b;
    logic            lst;
    logic            typed;
    logic [CP_W-1:0] cp;
    logic            bad;
    logic            eor;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h41,     1'b0, 1'b1, 21'h000041, 1'b0, 1'b0},
    '{8'h00,     1'b0, 1'b1, 21'h000000, 1'b0, 1'b0},
    '{8'hFF,     1'b0, 1'b1, 21'h0000FF, 1'b0, 1'b0},
    '{8'h80,     1'b0, 1'b1, 21'h000080, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_LN,     1'b0, 1'b1, 21'h00000A, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_DQUOTE, 1'b0, 1'b1, 21'h000022, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_LX,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'h47,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'h31,     1'b0, 1'b1, 21'h000000, 1'b1, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_LU,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_0,      1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_UX,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_UF,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 1'b1, 21'h0000FF, 1'b0, 1'b0},
    '{8'hF4,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'h8F,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'hBF,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'hBF,     1'b0, 1'b1, 21'h10FFFF, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b1, 1'b1, 21'h00005C, 1'b0, 1'b1},
    '{CH_BSLASH, 1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{CH_LU,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'h31,     1'b0, 1'b0, 21'h000000, 1'b0, 1'b0},
    '{8'h32,     1'b1, 1'b0, 21'h000000, 1'b0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  esc_u8_in_if  in_if ();
  esc_u8_out_if out_if ();

  escaped_utf8_to_code_points_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  cp_res_t     expected_cps [$];
  cp_res_t     step_cps [$];
  mode_e       mode_q = MODE_IDLE;
  seq_t        held = '{default: '0};
  int unsigned held_cnt = 0;
  int unsigned need_cnt = 0;

  logic        calm = 1'b0;
  logic        long_hold_req = 1'b0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned cps_checked = 0;
  int unsigned bad_seen = 0;
  int unsigned ends_seen = 0;
  int unsigned stuck_cycles = 0;

  function automatic int hex_val(byte_t c);
    if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic [CP_W-1:0] hex_value(input seq_t d, input int unsigned start,
                                                input int unsigned len, output logic bad);
    int unsigned     i;
    logic [CP_W-1:0] v;
    i = 0;
    v = '0;
    if (len >= 3 && d[start] == CH_0 && (d[start+1] == CH_LX || d[start+1] == CH_UX) &&
        hex_val(d[start+2]) >= 0) begin
      i = 2;
    end
    if (i >= len || hex_val(d[start+i]) < 0) begin
      bad = 1'b1;
      return '0;
    end
    bad = 1'b0;
    while (i < len && hex_val(d[start+i]) >= 0) begin
      v = (v << 4) | CP_W'(hex_val(d[start+i]));
      i++;
    end
    return v;
  endfunction

  function automatic int unsigned lead_len(byte_t c);
    casez (c)
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CP_W-1:0] join_utf8(input seq_t d, input int unsigned start,
                                                input int unsigned follow);
    logic [CP_W-1:0] v;
    int unsigned     k;
    v = '0;
    case (follow)
      1: v[4:0] = d[start][4:0];
      2: v[3:0] = d[start][3:0];
      default: v[2:0] = d[start][2:0];
    endcase
    for (k = 1; k <= follow; k++) begin
      v = {v[CP_W-7:0], d[start+k][5:0]};
    end
    return v;
  endfunction

  function automatic logic [CP_W-1:0] plain_escape(byte_t e);
    logic [CP_W-1:0] v;
    case (e)
      CH_LN: v = CP_W'(CH_NL);
      CH_LR: v = CP_W'(CH_CR);
      CH_LT: v = CP_W'(CH_TAB);
      CH_0: v = CP_W'(CH_NUL);
      default: v = CP_W'(e);
    endcase
    return v;
  endfunction

  function automatic void emit_cp(logic [CP_W-1:0] cp, logic bad);
    cp_res_t r;
    r = '{cp, bad, 1'b0};
    if (step_cps.size() < MAX_CPS) step_cps = {step_cps, r};
  endfunction

  function automatic void decode_tail(input seq_t t, input int unsigned n);
    int unsigned     i;
    int unsigned     dl;
    int unsigned     f;
    logic [CP_W-1:0] cp;
    logic            bad;
    byte_t           e;
    i = 0;
    while (i < n) begin
      bad = 1'b0;
      if (t[i] == CH_BSLASH && i + 1 < n) begin
        i++;
        e = t[i];
        if (e == CH_LX || e == CH_LU) begin
          dl = (e == CH_LX) ? 2 : 4;
          cp = '0;
          if (i + dl < n) begin
            cp = hex_value(t, i + 1, dl, bad);
            i += dl;
          end
        end else begin
          cp = plain_escape(e);
        end
        i++;
      end else begin
        f = lead_len(t[i]);
        if (f != 0 && i + f < n) begin
          cp = join_utf8(t, i, f);
          i += f + 1;
        end else begin
          cp = CP_W'(t[i]);
          i++;
        end
      end
      emit_cp(cp, bad);
    end
  endfunction

  function automatic void go_idle();
    mode_q = MODE_IDLE;
    held_cnt = 0;
    need_cnt = 0;
  endfunction

  // Advances the decoder state by one byte and leaves its code points in step_cps.
  function automatic void decode_byte(byte_t b, logic lst);
    seq_t            t;
    int unsigned     n;
    int unsigned     j;
    logic            bad;
    logic [CP_W-1:0] v;
    step_cps.delete();
    t = '{default: '0};
    n = 0;
    if (lst) begin
      case (mode_q)
        MODE_UTF8: begin
          for (j = 0; j < held_cnt; j++) begin
            t[n] = held[j];
            n++;
          end
        end
        MODE_ESC: begin
          t[0] = CH_BSLASH;
          n = 1;
        end
        MODE_HEX_X, MODE_HEX_U: begin
          t[0] = CH_BSLASH;
          t[1] = (mode_q == MODE_HEX_X) ? CH_LX : CH_LU;
          n = 2;
          for (j = 0; j < held_cnt; j++) begin
            t[n] = held[j];
            n++;
          end
        end
        default: ;
      endcase
      t[n] = b;
      n++;
      decode_tail(t, n);
      if (step_cps.size() > 0) begin
        step_cps[step_cps.size() - 1].eor = 1'b1;
      end
      go_idle();
      return;
    end
    case (mode_q)
      MODE_UTF8: begin
        held[held_cnt] = b;
        held_cnt++;
        need_cnt--;
        if (need_cnt == 0) begin
          emit_cp(join_utf8(held, 0, held_cnt - 1), 1'b0);
          go_idle();
        end
      end
      MODE_ESC: begin
        if (b == CH_LX || b == CH_LU) begin
          mode_q = (b == CH_LX) ? MODE_HEX_X : MODE_HEX_U;
          held_cnt = 0;
          need_cnt = (b == CH_LX) ? 2 : 4;
        end else begin
          emit_cp(plain_escape(b), 1'b0);
          go_idle();
        end
      end
      MODE_HEX_X, MODE_HEX_U: begin
        held[held_cnt] = b;
        held_cnt++;
        need_cnt--;
        if (need_cnt == 0) begin
          v = hex_value(held, 0, held_cnt, bad);
          emit_cp(v, bad);
          go_idle();
        end
      end
      default: begin
        if (b == CH_BSLASH) begin
          mode_q = MODE_ESC;
        end else if (lead_len(b) == 0) begin
          emit_cp(CP_W'(b), 1'b0);
          go_idle();
        end else begin
          mode_q = MODE_UTF8;
          held[0] = b;
          held_cnt = 1;
          need_cnt = lead_len(b);
        end
      end
    endcase
  endfunction

  function automatic byte_t hex_char();
    int unsigned r;
    r = $urandom_range(0, 23);
    if (r < 10) return CH_0 + byte_t'(r);
    if (r < 16) return CH_LA + byte_t'(r - 10);
    if (r < 22) return CH_UA + byte_t'(r - 16);
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(string what, logic [CP_W-1:0] want,
                                      logic [CP_W-1:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic push_byte(input stim_row_t row);
    cp_res_t r;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.byte_req <= row.b;
    in_if.last     <= row.lst;
    do @(posedge clk_i); while (!in_if.ready);
    decode_byte(row.b, row.lst);
    if (row.typed) begin
      r = '{row.cp, row.bad, row.eor};
      expected_cps = {expected_cps, r};
    end else begin
      expected_cps = {expected_cps, step_cps};
    end
    bytes_sent++;
    if (row.lst) strings_sent++;
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req <= 1'b0;
      end
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        hold = $urandom_range(1, 17) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cp_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_cps.size() == 0) begin
        $display("%0t: unexpected code point, expected none, got 0x%0h", $time,
                 out_if.code_point);
        errors++;
      end else begin
        want = expected_cps.pop_front();
        check_field("code_point", want.cp, out_if.code_point);
        check_field("bad_hex", CP_W'(want.bad), CP_W'(out_if.bad_hex));
        check_field("end_of_run", CP_W'(want.eor), CP_W'(out_if.end_of_run));
        cps_checked++;
        if (out_if.bad_hex) bad_seen++;
        if (out_if.end_of_run) ends_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("escaped_utf8_to_code_points_unit_test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    stim_row_t   row;
    byte_t       str_q [$];
    byte_t       b;
    int unsigned rand_items;
    int unsigned tok;
    int unsigned f;
    int unsigned k;
    bit          hold_asked;
    bit          drain_asked;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.byte_req <= '0;
    in_if.last     <= 1'b0;
    hold_asked     = 1'b0;
    drain_asked    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < N_DIRECTED; i++) push_byte(DIRECTED_ROWS[i]);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      calm = (rand_items >= RAND_ITEMS - CALM_ITEMS);
      str_q.delete();
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 8)) str_q = {str_q, byte_t'($urandom_range(0, 255))};
      end else begin
        repeat ($urandom_range(1, 6)) begin
          tok = $urandom_range(0, 9);
          case (tok)
            0, 1, 2: begin
              b = byte_t'($urandom_range(0, 127));
              str_q = {str_q, (b == CH_BSLASH) ? CH_LA : b};
            end
            3: begin
              str_q = {str_q, CH_BSLASH};
              case ($urandom_range(0, 6))
                0: b = CH_LN;
                1: b = CH_LR;
                2: b = CH_LT;
                3: b = CH_BSLASH;
                4: b = CH_DQUOTE;
                5: b = CH_0;
                default: begin
                  b = byte_t'($urandom_range(0, 255));
                  if (b == CH_LX || b == CH_LU) b = CH_LA;
                end
              endcase
              str_q = {str_q, b};
            end
            4: begin
              str_q = {str_q, CH_BSLASH, CH_LX};
              repeat (2) str_q = {str_q, hex_char()};
            end
            5: begin
              str_q = {str_q, CH_BSLASH, CH_LU};
              if ($urandom_range(0, 3) == 0) begin
                str_q = {str_q, CH_0};
                str_q = {str_q, $urandom_range(0, 1) ? CH_LX : CH_UX};
                repeat (2) str_q = {str_q, hex_char()};
              end else begin
                repeat (4) str_q = {str_q, hex_char()};
              end
            end
            6, 7, 8: begin
              f = tok - 5;
              b = byte_t'($urandom_range(0, 255)) >> (f + 2);
              str_q = {str_q, byte_t'(8'hFF << (7 - f)) | b};
              repeat (f) begin
                if ($urandom_range(0, 7) == 0) begin
                  str_q = {str_q, byte_t'($urandom_range(0, 255))};
                end else begin
                  str_q = {str_q, 8'h80 | byte_t'($urandom_range(0, 63))};
                end
              end
            end
            default: begin
              if ($urandom_range(0, 1)) begin
                str_q = {str_q, 8'h80 | byte_t'($urandom_range(0, 63))};
              end else begin
                str_q = {str_q, 8'hF8 | byte_t'($urandom_range(0, 7))};
              end
            end
          endcase
        end
        if (str_q.size() > 1 && $urandom_range(0, 2) == 0) begin
          k = $urandom_range(1, (str_q.size() > 3) ? 3 : str_q.size() - 1);
          repeat (k) void'(str_q.pop_back());
        end
      end
      foreach (str_q[j]) begin
        row = '0;
        row.b = str_q[j];
        row.lst = (j == str_q.size() - 1);
        push_byte(row);
        rand_items++;
      end
      // The receiver holds off long enough for the block to back up onto its input.
      if (!hold_asked && rand_items >= HOLD_AT) begin
        long_hold_req <= 1'b1;
        hold_asked = 1'b1;
      end
      if (!drain_asked && rand_items >= DRAIN_AT) begin
        drain_asked = 1'b1;
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        while (expected_cps.size() != 0) @(posedge clk_i);
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings: escapes, hex escapes, UTF-8 and cut-off endings.",
             bytes_sent, strings_sent);
    $display("Checked %0d code points, %0d with bad hex and %0d string ends; %0d mismatches.",
             cps_checked, bad_seen, ends_seen, errors);
    if (errors == 0) begin
      $display("escaped_utf8_to_code_points_unit_test passed");
    end else begin
      $display("escaped_utf8_to_code_points_unit_test failed");
    end
    $finish;
  end

endmodule
